@@ rtl/mftd_pkg.sv @@
`default_nettype none
package mftd_pkg;

   localparam int DispWidthDefault  = 128;
   localparam int DispHeightDefault = 64;
   localparam int QueueDepth        = 2;

   typedef enum logic [2:0] {
      KIND_CLEAR  = 3'd0,
      KIND_PIXEL  = 3'd1,
      KIND_RECT   = 3'd2,
      KIND_GLYPH  = 3'd3,
      KIND_COLUMN = 3'd4,
      KIND_READ   = 3'd5,
      KIND_NONE6  = 3'd6,
      KIND_NONE7  = 3'd7
   } kind_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] end_x;
      logic [7:0] end_y;
      logic       ink;
      logic [7:0] char_code;
      logic       large_req;
      logic [7:0] pattern;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] next_x;
      logic [7:0] next_y;
      logic       text_end;
   } rsp_type;

   // Decoded command handed from front to back.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] end_x;
      logic [7:0] end_y;
      logic       ink;
      logic       double_size;
      logic [7:0] pattern;
      logic [5:0] glyph;
      logic [7:0] next_x;
      logic [7:0] next_y;
      logic       text_end;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_READ,
      ST_WRITE,
      ST_RESULT
   } back_state_type;

   typedef enum logic [1:0] {
      PH_TOP,
      PH_BOTTOM,
      PH_LEFT,
      PH_RIGHT
   } rect_phase_type;

   localparam logic [5:0] GlyphBlank = 6'd40;

   function automatic logic [5:0] glyph_index(input logic [7:0] code);
      logic [7:0] c;
      logic [5:0] g;
      c = code;
      if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
      g = GlyphBlank;
      if (c >= 8'h30 && c <= 8'h39) g = 6'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h5A) g = 6'(c - 8'h41 + 8'd10);
      else if (c == 8'h2D) g = 6'd36;
      else if (c == 8'h3A) g = 6'd37;
      else if (c == 8'h2F) g = 6'd38;
      else if (c == 8'h2E) g = 6'd39;
      return g;
   endfunction

   function automatic logic [39:0] font_row(input logic [5:0] g);
      logic [39:0] r;
      unique case (g)
         6'd0:  r = 40'h3E_51_49_45_3E;
         6'd1:  r = 40'h00_42_7F_40_00;
         6'd2:  r = 40'h42_61_51_49_46;
         6'd3:  r = 40'h21_41_45_4B_31;
         6'd4:  r = 40'h18_14_12_7F_10;
         6'd5:  r = 40'h27_45_45_45_39;
         6'd6:  r = 40'h3C_4A_49_49_30;
         6'd7:  r = 40'h01_71_09_05_03;
         6'd8:  r = 40'h36_49_49_49_36;
         6'd9:  r = 40'h06_49_49_29_1E;
         6'd10: r = 40'h7E_11_11_11_7E;
         6'd11: r = 40'h7F_49_49_49_36;
         6'd12: r = 40'h3E_41_41_41_22;
         6'd13: r = 40'h7F_41_41_22_1C;
         6'd14: r = 40'h7F_49_49_49_41;
         6'd15: r = 40'h7F_09_09_09_01;
         6'd16: r = 40'h3E_41_49_49_7A;
         6'd17: r = 40'h7F_08_08_08_7F;
         6'd18: r = 40'h00_41_7F_41_00;
         6'd19: r = 40'h20_40_41_3F_01;
         6'd20: r = 40'h7F_08_14_22_41;
         6'd21: r = 40'h7F_40_40_40_40;
         6'd22: r = 40'h7F_02_0C_02_7F;
         6'd23: r = 40'h7F_04_08_10_7F;
         6'd24: r = 40'h3E_41_41_41_3E;
         6'd25: r = 40'h7F_09_09_09_06;
         6'd26: r = 40'h3E_41_51_21_5E;
         6'd27: r = 40'h7F_09_19_29_46;
         6'd28: r = 40'h46_49_49_49_31;
         6'd29: r = 40'h01_01_7F_01_01;
         6'd30: r = 40'h3F_40_40_40_3F;
         6'd31: r = 40'h1F_20_40_20_1F;
         6'd32: r = 40'h3F_40_38_40_3F;
         6'd33: r = 40'h63_14_08_14_63;
         6'd34: r = 40'h07_08_70_08_07;
         6'd35: r = 40'h61_51_49_45_43;
         6'd36: r = 40'h08_08_08_08_08;
         6'd37: r = 40'h00_36_36_00_00;
         6'd38: r = 40'h20_10_08_04_02;
         6'd39: r = 40'h00_60_60_00_00;
         default: r = 40'h0;
      endcase
      return r;
   endfunction

   // Column a of a glyph, a in 0..4 (first column in the top byte).
   function automatic logic [7:0] font_col(input logic [5:0] g, input logic [2:0] a);
      logic [39:0] r;
      logic [7:0]  col;
      r = font_row(g);
      unique case (a)
         3'd0:    col = r[39:32];
         3'd1:    col = r[31:24];
         3'd2:    col = r[23:16];
         3'd3:    col = r[15:8];
         3'd4:    col = r[7:0];
         default: col = 8'h00;
      endcase
      return col;
   endfunction

endpackage
`default_nettype wire

@@ rtl/mftd_front.sv @@
`default_nettype none
module mftd_front
   import mftd_pkg::*;
#(
   parameter int DISP_WIDTH  = DispWidthDefault,
   parameter int DISP_HEIGHT = DispHeightDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         q_valid,
   input  wire logic    q_take,
   output cmd_type      q_cmd
);

   localparam int QW = $clog2(QueueDepth);

   cmd_type       cmd_mem [QueueDepth];
   logic [QW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QW:0]   count_ff;
   logic          push, pop;
   cmd_type       dec;
   logic [7:0]    adv_x, adv_y;
   logic [8:0]    step_x;

   always_comb begin
      dec             = '0;
      dec.kind        = kind_type'(req_data.kind);
      dec.pos_x       = req_data.pos_x;
      dec.pos_y       = req_data.pos_y;
      dec.end_x       = req_data.end_x;
      dec.end_y       = req_data.end_y;
      dec.ink         = req_data.ink;
      dec.double_size = req_data.large_req;
      dec.pattern     = req_data.pattern;
      dec.glyph       = glyph_index(req_data.char_code);
      step_x          = req_data.large_req ? 9'd12 : 9'd6;
      adv_x           = req_data.pos_x + step_x[7:0];
      adv_y           = req_data.pos_y + (req_data.large_req ? 8'd16 : 8'd8);
      dec.next_x      = adv_x;
      dec.next_y      = req_data.pos_y;
      if ({1'b0, adv_x} > 9'(DISP_WIDTH) - step_x) begin
         dec.next_x = 8'd0;
         dec.next_y = adv_y;
      end
      dec.text_end = ({1'b0, dec.next_y} >= 9'(DISP_HEIGHT));
      if (dec.kind != KIND_GLYPH) begin
         dec.next_x   = 8'd0;
         dec.next_y   = 8'd0;
         dec.text_end = 1'b0;
      end
   end

   assign req_stall = (count_ff == (QW+1)'(QueueDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_take;
   assign q_cmd     = cmd_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) cmd_mem[wr_ptr_ff] <= dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QW+1)'(push) - (QW+1)'(pop);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QW+1)'(QueueDepth)) else $error("queue overfilled");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (QW+1)'(QueueDepth)) |-> !push) else $error("push into full queue");
   a_pop_track: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1)) else $error("count slip");

endmodule
`default_nettype wire

@@ rtl/mftd_back.sv @@
`default_nettype none
module mftd_back
   import mftd_pkg::*;
#(
   parameter int DISP_WIDTH  = DispWidthDefault,
   parameter int DISP_HEIGHT = DispHeightDefault
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  q_valid,
   output logic       q_take,
   input  cmd_type    q_cmd,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output rsp_type    rsp_data
);

   localparam int Pages = (DISP_HEIGHT + 7) / 8;
   localparam int Depth = DISP_WIDTH * Pages;
   localparam int AW    = $clog2(Depth);

   logic [7:0] store_mem [Depth];
   logic [7:0] rd_q_ff;

   back_state_type state_ff, state_in;
   rect_phase_type phase_ff, phase_in;
   cmd_type        cmd_ff;
   logic [AW:0]    clr_ff, clr_in;
   // walk counters: a = outer index, b = inner index
   logic [8:0]     a_ff, a_in;
   logic [3:0]     b_ff, b_in;
   logic           clearing_ff, clearing_in;

   logic [7:0]    px, py;
   logic          pv;
   logic          walk_done;
   logic          advance;
   logic [AW-1:0] addr_ff, addr_in;
   logic [2:0]    bit_ff, bit_in;
   logic [7:0]    rdata_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_load;
   logic          do_wr, do_rd;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [7:0]    col_byte;
   logic          sc;
   logic [7:0]    page_idx;
   logic [15:0]   addr_full;

   assign sc = cmd_ff.double_size;
   // a counts scaled columns; halve it at scale 2 to pick the font column
   assign col_byte = font_col(cmd_ff.glyph, sc ? a_ff[3:1] : a_ff[2:0]);

   // Current walk point and whether it sets a pixel.
   always_comb begin
      px = 8'd0;
      py = 8'd0;
      pv = 1'b0;
      walk_done = 1'b0;
      unique case (cmd_ff.kind)
         KIND_PIXEL: begin
            px = cmd_ff.pos_x; py = cmd_ff.pos_y; pv = 1'b1;
            walk_done = 1'b1;
         end
         KIND_RECT: begin
            unique case (phase_ff)
               PH_TOP:    begin px = a_ff[7:0]; py = cmd_ff.pos_y; end
               PH_BOTTOM: begin px = a_ff[7:0]; py = cmd_ff.end_y; end
               PH_LEFT:   begin px = cmd_ff.pos_x; py = a_ff[7:0]; end
               PH_RIGHT:  begin px = cmd_ff.end_x; py = a_ff[7:0]; end
               default:   ;
            endcase
            pv = (phase_ff == PH_TOP || phase_ff == PH_BOTTOM)
                 ? ({1'b0, cmd_ff.pos_x} <= a_ff && a_ff <= {1'b0, cmd_ff.end_x})
                 : ({1'b0, cmd_ff.pos_y} <= a_ff && a_ff <= {1'b0, cmd_ff.end_y});
            // an empty span starts past its end, so this also ends it
            walk_done = (phase_ff == PH_RIGHT) && (a_ff >= {1'b0, cmd_ff.end_y});
         end
         KIND_GLYPH: begin
            // a: column 0..5*s-1, b: row 0..7*s-1
            px = cmd_ff.pos_x + a_ff[7:0];
            py = cmd_ff.pos_y + {4'd0, b_ff};
            pv = sc ? col_byte[b_ff[3:1]] : col_byte[b_ff[2:0]];
            walk_done = (a_ff == (sc ? 9'd9 : 9'd4)) &&
                        (b_ff == (sc ? 4'd13 : 4'd6));
         end
         KIND_COLUMN: begin
            px = cmd_ff.pos_x + cmd_ff.end_x;
            py = cmd_ff.pos_y + {cmd_ff.end_y[4:0], 3'b000} + {5'd0, b_ff[2:0]};
            pv = cmd_ff.pattern[b_ff[2:0]];
            walk_done = (b_ff == 4'd7);
         end
         KIND_READ: begin
            px = cmd_ff.pos_x; py = cmd_ff.pos_y; pv = 1'b1;
            walk_done = 1'b1;
         end
         default: walk_done = 1'b1;
      endcase
      if ({1'b0, px} >= 9'(DISP_WIDTH) || {1'b0, py} >= 9'(DISP_HEIGHT)) pv = 1'b0;
   end

   always_comb begin
      page_idx  = {3'd0, py[7:3]};
      addr_full = 16'(px) + 16'(page_idx) * 16'(DISP_WIDTH);
   end

   assign advance  = (state_ff == ST_WALK && !pv && !walk_done) ||
                     (state_ff == ST_WRITE && !walk_done);
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      addr_in     = addr_ff;
      bit_in      = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               phase_in = PH_TOP;
               a_in = '0;
               b_in = '0;
               if (q_cmd.kind == KIND_RECT) a_in = {1'b0, q_cmd.pos_x};
               if (q_cmd.kind == KIND_CLEAR) begin
                  clr_in = '0;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(Depth - 1)) begin
               clearing_in = 1'b0;
               // the sweep after reset answers no command
               state_in = clearing_ff ? ST_IDLE : ST_RESULT;
            end
         end
         ST_WALK: begin
            addr_in = addr_full[AW-1:0];
            bit_in  = py[2:0];
            if (pv) state_in = ST_READ;
            else if (walk_done) state_in = ST_RESULT;
         end
         ST_READ: begin
            state_in = (cmd_ff.kind == KIND_READ) ? ST_RESULT : ST_WRITE;
         end
         ST_WRITE: begin
            state_in = walk_done ? ST_RESULT : ST_WALK;
         end
         ST_RESULT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // advance after a skipped point or after a write
      if (advance) begin
         unique case (cmd_ff.kind)
            KIND_RECT: begin
               if (phase_ff == PH_TOP) begin
                  phase_in = PH_BOTTOM;
               end else if (phase_ff == PH_BOTTOM) begin
                  if (a_ff >= {1'b0, cmd_ff.end_x}) begin
                     phase_in = PH_LEFT;
                     a_in = {1'b0, cmd_ff.pos_y};
                  end else begin
                     phase_in = PH_TOP;
                     a_in = a_ff + 1'b1;
                  end
               end else if (phase_ff == PH_LEFT) begin
                  phase_in = PH_RIGHT;
               end else begin
                  phase_in = PH_LEFT;
                  a_in = a_ff + 1'b1;
               end
            end
            KIND_GLYPH: begin
               if (b_ff == (sc ? 4'd13 : 4'd6)) begin
                  b_in = '0;
                  a_in = a_ff + 1'b1;
               end else begin
                  b_in = b_ff + 1'b1;
               end
            end
            default: b_in = b_ff + 1'b1;
         endcase
      end
   end

   assign q_take = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      do_rd   = (state_ff == ST_WALK) && pv;
      do_wr   = (state_ff == ST_WRITE) || (state_ff == ST_CLEAR);
      wr_addr = (state_ff == ST_CLEAR) ? clr_ff[AW-1:0] : addr_ff;
      if (state_ff == ST_CLEAR) wr_data = 8'h00;
      else if (cmd_ff.ink) wr_data = rd_q_ff | (8'h01 << bit_ff);
      else wr_data = rd_q_ff & ~(8'h01 << bit_ff);
   end

   always_ff @(posedge clock) begin
      if (do_wr) store_mem[wr_addr] <= wr_data;
      if (do_rd) rd_q_ff <= store_mem[addr_full[AW-1:0]];
   end

   // Load the result only when no result is held or the held one is being taken.
   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= '{rdata_ff, cmd_ff.next_x, cmd_ff.next_y, cmd_ff.text_end};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_TOP;
         a_ff         <= '0;
         b_ff         <= '0;
         clr_ff       <= '0;
         clearing_ff  <= 1'b1;
         addr_ff      <= '0;
         bit_ff       <= '0;
         cmd_ff       <= '0;
         rdata_ff     <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         a_ff        <= a_in;
         b_ff        <= b_in;
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
         addr_ff     <= addr_in;
         bit_ff      <= bit_in;
         if (q_take) cmd_ff <= q_cmd;
         if (q_take) rdata_ff <= 8'h00;
         else if (state_ff == ST_READ && cmd_ff.kind == KIND_READ) rdata_ff <= rd_q_ff;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> (state_ff == ST_IDLE)) else $error("take outside idle");
   a_wr_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> ($past(state_ff) == ST_READ)) else $error("write w/o read");
   a_result_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff) else $error("result dropped");

endmodule
`default_nettype wire

@@ rtl/mono_framebuffer_text_draw.sv @@
`default_nettype none
// Monochrome page-packed framebuffer drawing engine with a 5x7 font.
// Commands enter a two-entry queue; a single engine then walks each
// command pixel by pixel with a read-modify-write of one buffer byte
// per lit pixel (walk, read and write states), while a skipped point
// only advances the walk. Clear or reset sweeps the buffer one byte a
// cycle (DISP_WIDTH * ceil(DISP_HEIGHT/8) bytes, 1024 by default),
// during which no item is taken from the queue. One result item per
// command.
module mono_framebuffer_text_draw
   import mftd_pkg::*;
#(
   parameter int DISP_WIDTH  = DispWidthDefault,
   parameter int DISP_HEIGHT = DispHeightDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   logic    q_valid, q_take;
   cmd_type q_cmd;

   mftd_front #(.DISP_WIDTH(DISP_WIDTH), .DISP_HEIGHT(DISP_HEIGHT)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_cmd
   );

   mftd_back #(.DISP_WIDTH(DISP_WIDTH), .DISP_HEIGHT(DISP_HEIGHT)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_cmd,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
`default_nettype wire
